### rtl/core/ceq_pkg.sv
package ceq_pkg;
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_WAIT  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   localparam logic [3:0] KIND_MOVE  = 4'd0;
   localparam logic [3:0] KIND_TIMER = 4'd1;
   localparam logic [3:0] KIND_DOWN  = 4'd2;
   localparam logic [3:0] KIND_CLOSE = 4'd7;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  client;
      logic [3:0]  event_kind;
      logic [31:0] event_word;
      logic        client_ready;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  popped_kind;
      logic [31:0] popped_word;
      logic        merged;
      logic        evicted;
      logic        woke;
      logic        now_waiting;
      logic [31:0] overflows;
   } rsp_type;

   // front-to-back command: request plus the client check
   typedef struct packed {
      req_type req;
      logic    reject;
   } cmd_type;

   function automatic logic is_soft(input logic [3:0] k);
      return (k == KIND_MOVE) || (k == KIND_TIMER);
   endfunction

   function automatic logic is_edge(input logic [3:0] k);
      return (k >= KIND_DOWN) && (k <= KIND_CLOSE);
   endfunction
endpackage

### rtl/core/ceq_if.sv
interface ceq_req_if import ceq_pkg::*; ;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ceq_rsp_if import ceq_pkg::*; ;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/core/ceq_ram.sv
module ceq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### rtl/core/ceq_front.sv
module ceq_front import ceq_pkg::*; #(
   parameter int CLIENTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   ceq_req_if.sink req,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);
   // two-entry queue toward the back end
   cmd_type    q_ff [2];
   cmd_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    cls;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[0];

   always_comb begin
      cls.req = req.data;
      cls.reject = (req.data.client == 4'd0) ||
                   ({28'd0, req.data.client} >= 32'(CLIENTS));
   end

   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (cmd_pop) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = cls;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end
endmodule

### rtl/core/ceq_back.sv
module ceq_back import ceq_pkg::*; #(
   parameter int RING_SLOTS = 128,
   parameter int CLIENTS = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_pop,
   ceq_rsp_if.source rsp
);
   localparam int PW = $clog2(RING_SLOTS);
   localparam int CW = $clog2(CLIENTS);
   localparam int AW = PW + CW;
   localparam logic [PW-1:0] ONE = PW'(1);

   typedef enum logic [3:0] {
      S_IDLE, S_SRD, S_SCHK, S_VRD, S_VCHK, S_SHRD, S_SHWR, S_APP, S_DONE
   } state_type;

   state_type   state_ff;
   cmd_type     c_ff;
   logic [PW-1:0] wp_ff [CLIENTS];
   logic [PW-1:0] rp_ff [CLIENTS];
   logic [31:0]   ovf_ff [CLIENTS];
   logic [CLIENTS-1:0] wait_ff;
   logic [PW-1:0] s_ff, k_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [CW-1:0] cl, cmd_cl, rd_cl;
   logic [PW-1:0] head, tail;
   logic          wr_en;
   logic [PW-1:0] wr_slot, rd_slot;
   logic [3:0]    wr_kind, rd_kind;
   logic [31:0]   wr_word, rd_word;

   assign cl = c_ff.req.client[CW-1:0];
   assign cmd_cl = cmd.req.client[CW-1:0];
   // in idle the first read belongs to the command being taken
   assign rd_cl = (state_ff == S_IDLE) ? cmd_cl : cl;
   assign head = wp_ff[cl];
   assign tail = rp_ff[cl];

   ceq_ram #(.WIDTH(4), .DEPTH(CLIENTS * RING_SLOTS)) u_kind (
      .clock, .wr_en, .wr_addr({cl, wr_slot}), .wr_data(wr_kind),
      .rd_addr({rd_cl, rd_slot}), .rd_data(rd_kind));
   ceq_ram #(.WIDTH(32), .DEPTH(CLIENTS * RING_SLOTS)) u_word (
      .clock, .wr_en, .wr_addr({cl, wr_slot}), .wr_data(wr_word),
      .rd_addr({rd_cl, rd_slot}), .rd_data(rd_word));

   // read address follows the state being entered
   always_comb begin
      unique case (state_ff)
         S_IDLE:  rd_slot = (cmd.req.opcode == OP_POP) ? rp_ff[cmd_cl]
                          : wp_ff[cmd_cl] - ONE;
         default: rd_slot = s_ff;
      endcase
      wr_en = 1'b0;
      wr_slot = s_ff;
      wr_kind = c_ff.req.event_kind;
      wr_word = c_ff.req.event_word;
      unique case (state_ff)
         S_SHWR: begin
            wr_en = 1'b1;
            wr_kind = rd_kind;
            wr_word = rd_word;
         end
         S_APP: wr_en = 1'b1;
         S_SCHK: wr_en = (rd_kind == c_ff.req.event_kind);
         default: ;
      endcase
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;
   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid && !rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wait_ff <= '0;
         for (int i = 0; i < CLIENTS; i++) begin
            wp_ff[i] <= '0;
            rp_ff[i] <= '0;
            ovf_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_pop) begin
                  c_ff <= cmd;
                  rsp_ff <= '0;
                  s_ff <= (cmd.req.opcode == OP_POP) ? rp_ff[cmd.req.client[CW-1:0]]
                        : wp_ff[cmd.req.client[CW-1:0]] - ONE;
                  state_ff <= S_DONE;
                  if (!cmd.reject) begin
                     unique case (op_type'(cmd.req.opcode))
                        OP_PUSH: begin
                           if (is_soft(cmd.req.event_kind) &&
                               wp_ff[cmd.req.client[CW-1:0]] !=
                               rp_ff[cmd.req.client[CW-1:0]]) begin
                              state_ff <= S_SRD;
                           end else begin
                              // append goes straight to the head slot
                              s_ff <= wp_ff[cmd.req.client[CW-1:0]];
                              state_ff <= S_APP;
                           end
                        end
                        default: state_ff <= S_SRD;
                     endcase
                  end
               end
            end
            S_SRD: begin
               // read data arrives; for pop/wait/clear finish here
               unique case (op_type'(c_ff.req.opcode))
                  OP_PUSH: state_ff <= S_SCHK;
                  OP_POP: begin
                     if (head != tail) begin
                        rsp_ff.ok <= 1'b1;
                        rsp_ff.popped_kind <= rd_kind;
                        rsp_ff.popped_word <= rd_word;
                        rp_ff[cl] <= tail + ONE;
                     end
                     state_ff <= S_DONE;
                  end
                  OP_WAIT: begin
                     if (head == tail && c_ff.req.client_ready) begin
                        wait_ff[cl] <= 1'b1;
                     end
                     rsp_ff.ok <= 1'b1;
                     state_ff <= S_DONE;
                  end
                  OP_CLEAR: begin
                     wp_ff[cl] <= '0;
                     rp_ff[cl] <= '0;
                     ovf_ff[cl] <= '0;
                     rsp_ff.ok <= 1'b1;
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_SCHK: begin
               if (rd_kind == c_ff.req.event_kind) begin
                  rsp_ff.merged <= 1'b1;
                  rsp_ff.ok <= 1'b1;
                  if (wait_ff[cl]) begin
                     wait_ff[cl] <= 1'b0;
                     rsp_ff.woke <= 1'b1;
                  end
                  state_ff <= S_DONE;
               end else if (is_edge(rd_kind) || s_ff == tail) begin
                  s_ff <= head;
                  state_ff <= S_APP;
               end else begin
                  s_ff <= s_ff - ONE;
                  state_ff <= S_SRD;
               end
            end
            S_APP: begin
               if (head + ONE == tail) begin
                  // full: look for the oldest soft entry
                  s_ff <= tail;
                  ovf_ff[cl] <= ovf_ff[cl] + 32'd1;
                  state_ff <= S_VRD;
               end else begin
                  wp_ff[cl] <= head + ONE;
                  rsp_ff.ok <= 1'b1;
                  if (wait_ff[cl]) begin
                     wait_ff[cl] <= 1'b0;
                     rsp_ff.woke <= 1'b1;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_VRD: begin
               if (s_ff == head) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_VCHK;
               end
            end
            S_VCHK: begin
               if (is_soft(rd_kind)) begin
                  k_ff <= s_ff + ONE;
                  s_ff <= s_ff + ONE;
                  rsp_ff.evicted <= 1'b1;
                  state_ff <= S_SHRD;
               end else begin
                  s_ff <= s_ff + ONE;
                  state_ff <= S_VRD;
               end
            end
            S_SHRD: begin
               // read of slot k issued here, written one down in S_SHWR
               if (k_ff == head) begin
                  wp_ff[cl] <= head - ONE;
                  s_ff <= head - ONE;
                  state_ff <= S_APP;
               end else begin
                  s_ff <= k_ff - ONE;
                  state_ff <= S_SHWR;
               end
            end
            S_SHWR: begin
               k_ff <= k_ff + ONE;
               s_ff <= k_ff + ONE;
               state_ff <= S_SHRD;
            end
            S_DONE: begin
               rsp_ff.now_waiting <= wait_ff[cl] & ~c_ff.reject;
               rsp_ff.overflows <= c_ff.reject ? 32'd0 : ovf_ff[cl];
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### rtl/core/coalescing_event_queue_top.sv
// Coalescing per-client event queue. Each client owns a ring of RING_SLOTS
// slots (RING_SLOTS-1 events) held in two shared RAMs. One request word yields
// one response word. A front stage checks the client and buffers two requests;
// the back sequencer does one RAM access per cycle and takes no new command
// while a response is still waiting to be taken. A soft push first searches
// backward for a matching kind to merge with, and a push into a full ring scans
// for the oldest soft entry and shifts the newer entries down over it.
module coalescing_event_queue_top import ceq_pkg::*; #(
   parameter int RING_SLOTS = 128,
   parameter int CLIENTS = 16
) (
   input logic       clock,
   input logic       reset,
   ceq_req_if.sink   req,
   ceq_rsp_if.source rsp
);
   logic    cmd_valid, cmd_pop;
   cmd_type cmd;

   ceq_front #(.CLIENTS(CLIENTS)) u_front (
      .clock, .reset, .req, .cmd_valid, .cmd, .cmd_pop);
   ceq_back #(.RING_SLOTS(RING_SLOTS), .CLIENTS(CLIENTS)) u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_pop, .rsp);
endmodule

### test/tb_coalescing_event_queue_top.sv
`timescale 1ns / 1ps

module tb_coalescing_event_queue_top;
   import ceq_pkg::*;

   localparam int SLOTS = 128;
   localparam int NCLIENTS = 16;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   bit   hold_rsp = 1'b0;

   always #1 clock = ~clock;

   ceq_req_if req_ch ();
   ceq_rsp_if rsp_ch ();

   coalescing_event_queue_top dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   class queue_scoreboard;
      logic [3:0]  kinds[NCLIENTS][SLOTS];
      logic [31:0] words[NCLIENTS][SLOTS];
      int unsigned wr[NCLIENTS];
      int unsigned rd[NCLIENTS];
      logic [31:0] tally[NCLIENTS];
      bit          waiting[NCLIENTS];
      rsp_type     pending[$];

      function new();
         foreach (wr[i]) begin
            wr[i] = 0; rd[i] = 0; tally[i] = 0; waiting[i] = 0;
         end
      endfunction

      function int unsigned fill(input int c);
         return (wr[c] + SLOTS - rd[c]) % SLOTS;
      endfunction

      function void note_request(input req_type r);
         rsp_type o;
         int c, head, tail, s, v, i, k;
         bit done, drop;
         c = r.client;
         o = '0;
         if (c == 0 || c >= NCLIENTS) begin
            pending.push_back(o);
            return;
         end
         head = wr[c]; tail = rd[c];
         case (op_type'(r.opcode))
            OP_PUSH: begin
               done = 0; drop = 0;
               if (is_soft(r.event_kind) && head != tail) begin
                  s = (head + SLOTS - 1) % SLOTS;
                  forever begin
                     if (kinds[c][s] == r.event_kind) begin
                        words[c][s] = r.event_word;
                        o.merged = 1; done = 1;
                        break;
                     end
                     if (is_edge(kinds[c][s]) || s == tail) break;
                     s = (s + SLOTS - 1) % SLOTS;
                  end
               end
               if (!done) begin
                  if ((head + 1) % SLOTS == tail) begin
                     v = tail;
                     while (v != head && !is_soft(kinds[c][v])) v = (v + 1) % SLOTS;
                     tally[c] += 1;
                     if (v == head) drop = 1;
                     else begin
                        i = v; k = (v + 1) % SLOTS;
                        while (k != head) begin
                           kinds[c][i] = kinds[c][k];
                           words[c][i] = words[c][k];
                           i = k; k = (k + 1) % SLOTS;
                        end
                        head = (head + SLOTS - 1) % SLOTS;
                        o.evicted = 1;
                     end
                  end
                  if (!drop) begin
                     kinds[c][head] = r.event_kind;
                     words[c][head] = r.event_word;
                     wr[c] = (head + 1) % SLOTS;
                     done = 1;
                  end else wr[c] = head;
               end
               if (done) begin
                  o.ok = 1;
                  if (waiting[c]) begin
                     waiting[c] = 0; o.woke = 1;
                  end
               end
            end
            OP_POP: begin
               if (head != tail) begin
                  o.popped_kind = kinds[c][tail];
                  o.popped_word = words[c][tail];
                  rd[c] = (tail + 1) % SLOTS;
                  o.ok = 1;
               end
            end
            OP_WAIT: begin
               if (head == tail && r.client_ready) waiting[c] = 1;
               o.ok = 1;
            end
            default: begin
               wr[c] = 0; rd[c] = 0; tally[c] = 0;
               o.ok = 1;
            end
         endcase
         o.now_waiting = waiting[c];
         o.overflows = tally[c];
         pending.push_back(o);
      endfunction

      task check_response(input rsp_type got);
         rsp_type w;
         if (pending.size() == 0) begin
            report("unexpected word", 32'(got.ok), 32'd0);
            return;
         end
         w = pending.pop_front();
         if (got.ok !== w.ok) report("ok", 32'(got.ok), 32'(w.ok));
         if (got.popped_kind !== w.popped_kind)
            report("popped_kind", 32'(got.popped_kind), 32'(w.popped_kind));
         if (got.popped_word !== w.popped_word)
            report("popped_word", got.popped_word, w.popped_word);
         if (got.merged !== w.merged) report("merged", 32'(got.merged), 32'(w.merged));
         if (got.evicted !== w.evicted) report("evicted", 32'(got.evicted), 32'(w.evicted));
         if (got.woke !== w.woke) report("woke", 32'(got.woke), 32'(w.woke));
         if (got.now_waiting !== w.now_waiting)
            report("now_waiting", 32'(got.now_waiting), 32'(w.now_waiting));
         if (got.overflows !== w.overflows) report("overflows", got.overflows, w.overflows);
      endtask
   endclass

   queue_scoreboard board = new();

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   // valid stays up between back-to-back words
   task automatic send_word(input req_type r);
      int gap;
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic send(input op_type op, input int c, input logic [3:0] k,
                       input logic [31:0] w, input bit rdy);
      req_type r;
      r.opcode = op; r.client = c[3:0]; r.event_kind = k;
      r.event_word = w; r.client_ready = rdy;
      send_word(r);
   endtask

   // random operation for the given client, content biased toward coalescing kinds
   task automatic send_random(input int c);
      int p;
      logic [3:0] k;
      p = $urandom_range(0, 99);
      k = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 1)) : 4'($urandom_range(0, 15));
      if (p < 55) send(OP_PUSH, c, k, $urandom, $urandom_range(0, 1));
      else if (p < 80) send(OP_POP, c, k, $urandom, $urandom_range(0, 1));
      else if (p < 93) send(OP_WAIT, c, k, $urandom, $urandom_range(0, 1));
      else send(OP_CLEAR, c, k, $urandom, $urandom_range(0, 1));
   endtask

   // receiver
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 13);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0 || hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (hold_rsp) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         board.check_response(rsp_ch.data);
      end
   end

   // watchdog on accepted words
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle = 0;
         else if (!hold_rsp) idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // long receiver hold-off while the sender keeps going
   initial begin
      @(negedge reset);
      repeat (3000) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (600) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      int n, c;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: rejected clients, empty pop, wait, extremes
      send(OP_PUSH, 0, KIND_MOVE, 32'hFFFF_FFFF, 1);
      send(OP_POP, 0, 4'd0, 32'd0, 0);
      send(OP_POP, 3, 4'd0, 32'd0, 0);
      send(OP_WAIT, 3, 4'd0, 32'd0, 0);
      send(OP_WAIT, 3, 4'hF, 32'd0, 1);
      send(OP_PUSH, 3, KIND_MOVE, 32'hFFFF_FFFF, 1);
      send(OP_PUSH, 3, KIND_MOVE, 32'h0000_0000, 0);
      send(OP_PUSH, 3, KIND_TIMER, 32'hA5A5_5A5A, 0);
      send(OP_PUSH, 3, KIND_DOWN, 32'h1, 0);
      send(OP_PUSH, 3, KIND_MOVE, 32'h2, 0);
      send(OP_WAIT, 3, 4'd0, 32'd0, 1);
      send(OP_PUSH, 3, 4'hF, 32'h3, 0);
      send(OP_POP, 3, 4'd0, 32'd0, 0);
      send(OP_POP, 3, 4'd0, 32'd0, 0);
      send(OP_CLEAR, 3, 4'd0, 32'd0, 0);
      send(OP_POP, 3, 4'd0, 32'd0, 0);
      send(OP_WAIT, 15, 4'd0, 32'd0, 1);
      send(OP_PUSH, 15, KIND_TIMER, 32'h5A5A_A5A5, 1);

      // full ring: edges only then a drop; then soft entries and eviction
      for (int i = 0; i < 128; i++) send(OP_PUSH, 5, 4'(2 + i % 6), $urandom, 0);
      send(OP_PUSH, 5, KIND_MOVE, 32'h77, 0);
      send(OP_CLEAR, 5, 4'd0, 32'd0, 0);
      for (int i = 0; i < 132; i++) send(OP_PUSH, 6, (i % 2) ? KIND_DOWN : 4'(8 + i % 8),
                                          $urandom, 0);
      send(OP_PUSH, 7, KIND_MOVE, 32'h1, 0);
      for (int i = 0; i < 127; i++) send(OP_PUSH, 7, 4'($urandom_range(2, 15)), $urandom, 0);
      for (int i = 0; i < 4; i++) send(OP_POP, 7, 4'd0, 32'd0, 0);

      // random: a few hot clients so rings interact, some rejected ones
      n = 0;
      while (n < 40) begin
         c = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
         send_random(c);
         n++;
      end
      req_ch.valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

### files.f
rtl/core/ceq_pkg.sv
rtl/core/ceq_if.sv
rtl/core/ceq_ram.sv
rtl/core/ceq_front.sv
rtl/core/ceq_back.sv
rtl/core/coalescing_event_queue_top.sv
test/tb_coalescing_event_queue_top.sv
